// ----- rtl/deq_pkg.sv -----
// Shared constants, codes and ring helpers for the double-ended queue.
package deq_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int FUNC_W  = 3;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    localparam logic [FUNC_W-1:0] OP_POP_FRONT  = 3'd0;
    localparam logic [FUNC_W-1:0] OP_POP_REAR   = 3'd1;
    localparam logic [FUNC_W-1:0] OP_PUSH_FRONT = 3'd2;
    localparam logic [FUNC_W-1:0] OP_PUSH_REAR  = 3'd3;
    localparam logic [FUNC_W-1:0] OP_LIST       = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } ram_req_t;

    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + (IDX_W + 1)'(off);
        if (sum >= (IDX_W + 1)'(DEPTH))
        begin
            sum = sum - (IDX_W + 1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] base);
        logic [IDX_W-1:0] res;
        if (base == '0)
        begin
            res = IDX_W'(DEPTH - 1);
        end
        else
        begin
            res = base - IDX_W'(1);
        end
        return res;
    endfunction

endpackage

// ----- rtl/deq_if.sv -----
// Request and response channel interfaces of the double-ended queue.
interface deq_in_if
    import deq_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic        [FUNC_W-1:0] func;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface deq_out_if
    import deq_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [DATA_W-1:0]  value_out;
    logic        [STAT_W-1:0]  status;
    logic                      last;
    logic        [COUNT_W-1:0] count;

    modport source (output valid, output value_out, output status, output last,
                    output count, input ready);
    modport sink   (input valid, input value_out, input status, input last,
                    input count, output ready);
endinterface

// ----- rtl/double_ended_queue_top.sv -----
// Top level of the double-ended queue: sequencer plus element store.
//
// The req channel takes one word per operation: func selects pop front,
// pop rear, push front, push rear or list, and value carries the element
// for a push. The rsp channel returns value_out, status, last and count.
// Every push and pop returns one word; a list returns one word per stored
// element, front to rear, with last set on the final one, or a single
// empty-status word when nothing is stored. Unused func codes are taken
// and return nothing.
// A push or pop is accepted in S_IDLE; S_RESP then loads its result from
// the store's registered read port into the output register, and req
// stays closed until then. A list issues its first read at acceptance;
// S_LIST then loads one word per cycle from the store's read port while
// the output register is free. A stalled receiver holds the output
// register; req stays open while the last result waits, and the
// sequencer waits for the register to free before loading the next word.
// Reset empties the queue at once: front index and count return to zero.
module double_ended_queue_top
    import deq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    deq_in_if.sink    req,
    deq_out_if.source rsp
);

    ram_req_t          ram_req;
    logic [DATA_W-1:0] ram_rdata;

    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    deq_ram #(
        .DATA_BITS (DATA_W),
        .WORDS     (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

endmodule

// ----- rtl/deq_ram.sv -----
// Simple dual-port RAM with one write port and one registered read port.
module deq_ram #(
    parameter int DATA_BITS = 32,
    parameter int WORDS     = 16,
    parameter int ADDR_BITS = (WORDS > 1) ? $clog2(WORDS) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [DATA_BITS-1:0] wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [DATA_BITS-1:0] rdata
);

    logic [DATA_BITS-1:0] mem [WORDS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/deq_ctrl.sv -----
// Sequencer: ring pointers, store access and the result word register.
module deq_ctrl
    import deq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    deq_in_if.sink             req,
    deq_out_if.source          rsp,
    output ram_req_t           ram_req,
    input  logic [DATA_W-1:0]  ram_rdata
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RESP = 3'b010,
        S_LIST = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    front_reg, front_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    lidx_reg, lidx_next;
    logic                rdsel_reg, rdsel_next;
    logic [STAT_W-1:0]   pst_reg, pst_next;

    logic                ov_reg, ov_next;
    logic [DATA_W-1:0]   oval_reg, oval_next;
    logic [STAT_W-1:0]   ost_reg, ost_next;
    logic                olast_reg, olast_next;
    logic [CNT_W-1:0]    ocnt_reg, ocnt_next;

    logic                accept;
    logic                slot_free;
    logic                is_empty;
    logic                is_full;
    logic                list_end;
    logic [IDX_W-1:0]    new_front;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign slot_free = !ov_reg || rsp.ready;
    assign is_empty  = (cnt_reg == '0);
    assign is_full   = (cnt_reg == CNT_W'(DEPTH));
    assign list_end  = ((lidx_reg + CNT_W'(1)) == cnt_reg);
    assign new_front = ring_dec(front_reg);

    always_comb
    begin
        state_next = state_reg;
        front_next = front_reg;
        cnt_next   = cnt_reg;
        lidx_next  = lidx_reg;
        rdsel_next = rdsel_reg;
        pst_next   = pst_reg;
        ov_next    = ov_reg && !rsp.ready;
        oval_next  = oval_reg;
        ost_next   = ost_reg;
        olast_next = olast_reg;
        ocnt_next  = ocnt_reg;
        ram_req    = '0;
        ram_req.wdata = req.value;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rdsel_next = 1'b0;
                    pst_next   = ST_OK;
                    case (req.func)
                        OP_POP_FRONT:
                        begin
                            state_next = S_RESP;
                            if (is_empty)
                            begin
                                pst_next = ST_EMPTY;
                            end
                            else
                            begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = front_reg;
                                front_next    = ring_add(front_reg, CNT_W'(1));
                                cnt_next      = cnt_reg - CNT_W'(1);
                                rdsel_next    = 1'b1;
                            end
                        end
                        OP_POP_REAR:
                        begin
                            state_next = S_RESP;
                            if (is_empty)
                            begin
                                pst_next = ST_EMPTY;
                            end
                            else
                            begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = ring_add(front_reg, cnt_reg - CNT_W'(1));
                                cnt_next      = cnt_reg - CNT_W'(1);
                                rdsel_next    = 1'b1;
                            end
                        end
                        OP_PUSH_FRONT:
                        begin
                            state_next = S_RESP;
                            if (is_full)
                            begin
                                pst_next = ST_FULL;
                            end
                            else
                            begin
                                ram_req.we    = 1'b1;
                                ram_req.waddr = new_front;
                                front_next    = new_front;
                                cnt_next      = cnt_reg + CNT_W'(1);
                            end
                        end
                        OP_PUSH_REAR:
                        begin
                            state_next = S_RESP;
                            if (is_full)
                            begin
                                pst_next = ST_FULL;
                            end
                            else
                            begin
                                ram_req.we    = 1'b1;
                                ram_req.waddr = ring_add(front_reg, cnt_reg);
                                cnt_next      = cnt_reg + CNT_W'(1);
                            end
                        end
                        OP_LIST:
                        begin
                            if (is_empty)
                            begin
                                state_next = S_RESP;
                                pst_next   = ST_EMPTY;
                            end
                            else
                            begin
                                state_next    = S_LIST;
                                ram_req.re    = 1'b1;
                                ram_req.raddr = front_reg;
                                lidx_next     = '0;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RESP:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    oval_next  = rdsel_reg ? ram_rdata : '0;
                    ost_next   = pst_reg;
                    olast_next = 1'b1;
                    ocnt_next  = cnt_reg;
                    state_next = S_IDLE;
                end
            end
            S_LIST:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    oval_next  = ram_rdata;
                    ost_next   = ST_OK;
                    olast_next = list_end;
                    ocnt_next  = cnt_reg;
                    if (list_end)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = ring_add(front_reg, lidx_reg + CNT_W'(1));
                        lidx_next     = lidx_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            front_reg <= '0;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lidx_reg  <= lidx_next;
        rdsel_reg <= rdsel_next;
        pst_reg   <= pst_next;
        oval_reg  <= oval_next;
        ost_reg   <= ost_next;
        olast_reg <= olast_next;
        ocnt_reg  <= ocnt_next;
    end

    assign rsp.valid     = ov_reg;
    assign rsp.value_out = oval_reg;
    assign rsp.status    = ost_reg;
    assign rsp.last      = olast_reg;
    assign rsp.count     = COUNT_W'(ocnt_reg);

endmodule

// ----- rtl/deq_checker.sv -----
// Port-level checks of the double-ended queue, bound to the top level.
module deq_checker
    import deq_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic [DATA_W-1:0]  rsp_value_out,
    input logic [STAT_W-1:0]  rsp_status,
    input logic               rsp_last,
    input logic [COUNT_W-1:0] rsp_count
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value_out)
            && $stable(rsp_status) && $stable(rsp_last) && $stable(rsp_count))
        else $error("rsp word changed while stalled");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_FULL) |-> rsp_count == COUNT_W'(DEPTH))
        else $error("full status with queue not full");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_EMPTY) |-> rsp_count == '0 && rsp_last
            && rsp_value_out == '0)
        else $error("empty status with stored elements or data");

    a_list_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_last |-> !req_ready)
        else $error("request taken in the middle of a list");

    a_req_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(req_ready) && !$past(req_valid) |-> 1'b0)
        else $error("req ready dropped without a request");

endmodule

bind double_ended_queue_top deq_checker u_deq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_value_out (rsp.value_out),
    .rsp_status    (rsp.status),
    .rsp_last      (rsp.last),
    .rsp_count     (rsp.count)
);

// ----- verif/double_ended_queue_top_tb.sv -----
// Self-checking testbench for double_ended_queue_top: directed table, then random operations.
module double_ended_queue_top_tb;
    import deq_pkg::*;

    localparam logic [FUNC_W-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [FUNC_W-1:0] OP_UNUSED_HI = 3'd7;
    localparam int RANDOM_OPS   = 120;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic signed [DATA_W-1:0]  value_out;
        logic        [STAT_W-1:0]  status;
        logic                      last;
        logic        [COUNT_W-1:0] count;
    } deq_word_t;

    typedef struct {
        logic        [FUNC_W-1:0] func;
        logic signed [DATA_W-1:0] value;
        bit                       typed;
        deq_word_t                word;
    } deq_row_t;

    logic clk = 1'b0;
    logic rst_n;

    deq_in_if  req_if ();
    deq_out_if rsp_if ();

    double_ended_queue_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    logic signed [DATA_W-1:0] ring [DEPTH];
    int unsigned head = 0;
    int unsigned fill = 0;

    deq_word_t step_words[$];
    deq_word_t expected_words[$];
    deq_row_t  plan[$];

    bit calm = 1'b0;
    int errors = 0;
    int cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("double_ended_queue_top test failed");
            $finish;
        end
    end

    initial
    begin
        rsp_if.ready = 1'b0;
    end

    always @(negedge clk)
    begin
        rsp_if.ready <= calm || ($urandom_range(99) >= 26);
    end

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        deq_word_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (expected_words.size() == 0)
            begin
                flag_mismatch("unexpected word", rsp_if.value_out, '0);
            end
            else
            begin
                want = expected_words.pop_front();
                if (rsp_if.value_out !== want.value_out)
                begin
                    flag_mismatch("value_out", rsp_if.value_out, want.value_out);
                end
                if (rsp_if.status !== want.status)
                begin
                    flag_mismatch("status", 32'(rsp_if.status), 32'(want.status));
                end
                if (rsp_if.last !== want.last)
                begin
                    flag_mismatch("last", 32'(rsp_if.last), 32'(want.last));
                end
                if (rsp_if.count !== want.count)
                begin
                    flag_mismatch("count", 32'(rsp_if.count), 32'(want.count));
                end
            end
        end
    end

    task automatic emit_word(input logic signed [DATA_W-1:0] val,
                             input logic [STAT_W-1:0] st, input logic lst);
        deq_word_t w;
        w.value_out = val;
        w.status    = st;
        w.last      = lst;
        w.count     = COUNT_W'(fill);
        step_words.push_back(w);
    endtask

    task automatic apply_deque_op(input logic [FUNC_W-1:0] f,
                                  input logic signed [DATA_W-1:0] v);
        logic signed [DATA_W-1:0] elem;
        int unsigned i;
        case (f)
            OP_POP_FRONT, OP_POP_REAR:
            begin
                if (fill == 0)
                begin
                    emit_word('0, ST_EMPTY, 1'b1);
                end
                else
                begin
                    if (f == OP_POP_FRONT)
                    begin
                        elem = ring[head];
                        head = (head + 1) % DEPTH;
                    end
                    else
                    begin
                        elem = ring[(head + fill - 1) % DEPTH];
                    end
                    fill--;
                    emit_word(elem, ST_OK, 1'b1);
                end
            end
            OP_PUSH_FRONT, OP_PUSH_REAR:
            begin
                if (fill == DEPTH)
                begin
                    emit_word('0, ST_FULL, 1'b1);
                end
                else
                begin
                    if (f == OP_PUSH_FRONT)
                    begin
                        head = (head + DEPTH - 1) % DEPTH;
                        ring[head] = v;
                    end
                    else
                    begin
                        ring[(head + fill) % DEPTH] = v;
                    end
                    fill++;
                    emit_word('0, ST_OK, 1'b1);
                end
            end
            OP_LIST:
            begin
                if (fill == 0)
                begin
                    emit_word('0, ST_EMPTY, 1'b1);
                end
                else
                begin
                    for (i = 0; i < fill; i++)
                    begin
                        emit_word(ring[(head + i) % DEPTH], ST_OK, (i + 1 == fill));
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic send_word(input logic [FUNC_W-1:0] f, input logic signed [DATA_W-1:0] v,
                             input bit typed, input deq_word_t word);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 26)
        begin
            req_if.valid <= 1'b0;
            req_if.func  <= FUNC_W'($urandom);
            req_if.value <= $urandom;
            @(negedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.func  <= f;
        req_if.value <= v;
        @(posedge clk);
        while (!req_if.ready)
        begin
            @(posedge clk);
        end
        apply_deque_op(f, v);
        if (typed)
        begin
            expected_words.push_back(word);
        end
        else
        begin
            foreach (step_words[i])
            begin
                expected_words.push_back(step_words[i]);
            end
        end
        step_words.delete();
    endtask

    task automatic add_row(input logic [FUNC_W-1:0] f, input logic signed [DATA_W-1:0] v,
                           input bit typed, input deq_word_t word);
        deq_row_t r;
        r.func  = f;
        r.value = v;
        r.typed = typed;
        r.word  = word;
        plan.push_back(r);
    endtask

    initial
    begin
        logic        [FUNC_W-1:0] f;
        logic signed [DATA_W-1:0] v;
        int pick;
        int push_pct;
        int sent;

        rst_n        = 1'b0;
        req_if.valid = 1'b0;
        req_if.func  = OP_POP_FRONT;
        req_if.value = '0;

        add_row(OP_LIST,       '0,           1'b1, '{32'sd0, ST_EMPTY, 1'b1, 5'd0});
        add_row(OP_POP_FRONT,  '0,           1'b1, '{32'sd0, ST_EMPTY, 1'b1, 5'd0});
        add_row(OP_POP_REAR,   -32'sd1,      1'b1, '{32'sd0, ST_EMPTY, 1'b1, 5'd0});
        add_row(OP_PUSH_REAR,  32'h7fffffff, 1'b1, '{32'sd0, ST_OK, 1'b1, 5'd1});
        add_row(OP_PUSH_FRONT, 32'h80000000, 1'b1, '{32'sd0, ST_OK, 1'b1, 5'd2});
        add_row(OP_LIST,       '0,           1'b0, '0);
        for (int i = 0; i < DEPTH - 2; i++)
        begin
            add_row((i % 2 == 0) ? OP_PUSH_FRONT : OP_PUSH_REAR,
                    DATA_W'(i + 1) * 32'h0101_0101, 1'b0, '0);
        end
        add_row(OP_PUSH_REAR,  32'h1234_5678, 1'b1, '{32'sd0, ST_FULL, 1'b1, 5'd16});
        add_row(OP_PUSH_FRONT, -32'sd1,       1'b1, '{32'sd0, ST_FULL, 1'b1, 5'd16});
        add_row(OP_LIST,       '0,            1'b0, '0);
        add_row(OP_POP_FRONT,  '0,            1'b0, '0);
        add_row(OP_POP_REAR,   '0,            1'b0, '0);
        add_row(OP_UNUSED_LO,  32'h5555_5555, 1'b0, '0);
        add_row(OP_UNUSED_HI,  32'haaaa_aaaa, 1'b0, '0);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            send_word(plan[i].func, plan[i].value, plan[i].typed, plan[i].word);
        end

        // swing between filling and draining so both ends of the ring get hit
        sent     = 0;
        push_pct = 70;
        while (sent < RANDOM_OPS)
        begin
            calm = (sent >= 60 && sent < 100);
            if (sent % 25 == 0)
            begin
                push_pct = (push_pct > 50) ? 25 : 75;
            end
            pick = $urandom_range(99);
            if (pick < 5)
            begin
                f = OP_UNUSED_LO + FUNC_W'($urandom_range(2));
            end
            else if (pick < 13)
            begin
                f = OP_LIST;
            end
            else if ($urandom_range(99) < push_pct)
            begin
                f = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
            end
            else
            begin
                f = $urandom_range(1) ? OP_POP_FRONT : OP_POP_REAR;
            end
            case ($urandom_range(7))
                0: v = 32'h8000_0000;
                1: v = 32'h7fff_ffff;
                2: v = -32'sd1;
                default: v = $urandom;
            endcase
            send_word(f, v, 1'b0, '0);
            if (f < OP_UNUSED_LO)
            begin
                sent++;
            end
        end

        calm = 1'b0;
        @(negedge clk);
        req_if.valid <= 1'b0;

        while (expected_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
        begin
            $display("double_ended_queue_top test passed");
        end
        else
        begin
            $display("double_ended_queue_top test failed");
        end
        $finish;
    end

endmodule
